[rtl/window_sigma_anomaly_scorer_macros.svh]
// Assertion macros for the window sigma anomaly scorer.
// Both sample on clock and are disabled while reset is high.
`ifndef WINDOW_SIGMA_ANOMALY_SCORER_MACROS_SVH
`define WINDOW_SIGMA_ANOMALY_SCORER_MACROS_SVH

// Same-cycle implication.
`define WSAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WSAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/wsas_pkg.sv]
// Package for the window sigma anomaly scorer: field widths, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package wsas_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_BITS = 8;
   localparam int ALPHA_W   = 9;
   localparam int SCORE_W   = 10;
   localparam int LEVEL_W   = 2;
   localparam int CHAN_W    = 2;
   localparam int STREAK_W  = 4;
   localparam int DIV_STEPS = 10;

   localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 9'd256;
   localparam logic [SCORE_W-1:0]  SCORE_MAX  = 10'd1000;
   localparam logic [STREAK_W-1:0] STREAK_MAX = 4'd15;

   localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_ANOM   = 2'd2;

   localparam logic [2:0] CSR_ALPHA      = 3'd0;
   localparam logic [2:0] CSR_LIMIT_GAS  = 3'd1;
   localparam logic [2:0] CSR_LIMIT_TEMP = 3'd2;
   localparam logic [2:0] CSR_LIMIT_HUM  = 3'd3;
   localparam logic [2:0] CSR_COMBO_TEMP = 3'd4;
   localparam logic [2:0] CSR_COMBO_HUM  = 3'd5;
   localparam logic [2:0] CSR_TREND_STEP = 3'd6;
   localparam logic [2:0] CSR_TREND_RUN  = 3'd7;

endpackage

[rtl/window_sigma_anomaly_scorer.sv]
// Window sigma anomaly scorer: low-pass filter, per-channel window statistics and scoring.
// Depends on wsas_pkg and window_sigma_anomaly_scorer_macros.svh.
//
// Usage:
//   req channel: tuser carries the channel, tdata the signed sample. One transaction
//   is taken at a time; req_tready is high only while the block is idle.
//   rsp channel: one transaction per request on a channel below CHANNEL_COUNT;
//   requests on other channels are dropped and give no response.
//   csr port: register writes land on the clock edge where csr_we is high.
//   Processing: filter and statistics steps through one shared multiplier, then
//   a bit-pair square root, then a restoring division, which is skipped when the
//   variance is zero or the deviation is at least the root; then rsp_tvalid.
//   The block handles one sample at a time and takes the next request only
//   after the current result has been delivered.
//   A stalled result holds in the output register and the block takes no new
//   request until it is delivered.
//   Reset clears the channel statistics and restores the register defaults; the
//   window memory needs no clearing since an entry is only read once written.
`timescale 1ns / 1ps
`include "window_sigma_anomaly_scorer_macros.svh"

module window_sigma_anomaly_scorer
   import wsas_pkg::*;
#(
   parameter int WINDOW_LEN    = 16,
   parameter int CHANNEL_COUNT = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] sample
   input  logic [CHAN_W-1:0]   req_tuser,   // [1:0] channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [15:0] smoothed_sample, [17:16] level,
                                            // [27:18] score, [31:28] zero
   output logic [CHAN_W-1:0]   rsp_tuser,   // [1:0] out_channel
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int LG     = $clog2(WINDOW_LEN);
   localparam int PW     = LG;
   localparam int NW     = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = SAMPLE_W + 1 + LG;
   localparam int SQ_W   = 2 * SAMPLE_W - 1 + LG;
   localparam int DW     = SAMPLE_W + 2 + LG;
   localparam int VW     = 2 * SAMPLE_W + 2 * LG;
   localparam int RW     = VW / 2;
   localparam int QW     = DW + SCORE_W;
   localparam int SM_W   = SAMPLE_W + FRAC_BITS;
   localparam int MA_W   = SQ_W + 1;
   localparam int MB_W   = DW + 1;
   localparam int MP_W   = MA_W + MB_W;
   localparam int CMP_W  = 2 * DW + 1;
   localparam int CNT_W  = $clog2(RW + 1);
   localparam int CW     = $clog2(CHANNEL_COUNT);
   localparam int DEPTH  = CHANNEL_COUNT * WINDOW_LEN;
   localparam int AW     = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_F2, ST_F3, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6,
      ST_LVL, ST_SQRT, ST_PREP, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff;

   logic [ALPHA_W-1:0]         alpha_ff;
   logic signed [SAMPLE_W-1:0] lim_gas_ff, lim_temp_ff, lim_hum_ff;
   logic [14:0]                combo_temp_ff, combo_hum_ff;
   logic [15:0]                trend_step_ff;
   logic [STREAK_W-1:0]        trend_run_ff;

   logic [PW-1:0]              pos_ff    [CHANNEL_COUNT];
   logic [NW-1:0]              fill_ff   [CHANNEL_COUNT];
   logic signed [SM_W-1:0]     sm_ff     [CHANNEL_COUNT];
   logic signed [SUM_W-1:0]    sum_ff    [CHANNEL_COUNT];
   logic [SQ_W-1:0]            sq_ff     [CHANNEL_COUNT];
   logic signed [SAMPLE_W-1:0] latest_ff [CHANNEL_COUNT];
   logic signed [SAMPLE_W-1:0] prev_ff   [CHANNEL_COUNT];
   logic [STREAK_W-1:0]        streak_ff [CHANNEL_COUNT];

   logic signed [SAMPLE_W-1:0] window_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_ff;

   logic [CHAN_W-1:0]          chan_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [MP_W-1:0]     acc_ff;
   logic signed [SAMPLE_W-1:0] v_ff;
   logic signed [SUM_W-1:0]    wsum_ff;
   logic [SQ_W-1:0]            wsq_ff;
   logic [NW-1:0]              n_ff;
   logic signed [DW-1:0]       d_ff;
   logic [VW-1:0]              nsq_ff, var_ff;
   logic [DW-1:0]              dmag_ff;
   logic [2*DW-1:0]            dsq_ff;
   logic [QW-1:0]              num_ff, rem_ff, den_ff;
   logic [VW-1:0]              x_ff, r_ff, bit_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [SCORE_W-1:0]         q_ff;
   logic [LEVEL_W-1:0]         level_ff;

   logic                       rsp_valid_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;
   logic signed [SAMPLE_W-1:0] rsp_v_ff;
   logic [LEVEL_W-1:0]         rsp_level_ff;
   logic [SCORE_W-1:0]         rsp_score_ff;

   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [MP_W-1:0]     mul_p_ff;

   logic [CW-1:0]              ci;
   logic [ALPHA_W-1:0]         alpha_sat, alpha_inv;
   logic [AW-1:0]              addr;
   logic                       full;
   logic [NW-1:0]              n_in;
   logic signed [MP_W-1:0]     num_sum, num_shr;
   logic signed [SM_W-1:0]     sm_in;
   logic signed [SM_W-1:0]     vq;
   logic signed [SAMPLE_W-1:0] v_in;
   logic [DW-1:0]              dmag_in;
   logic signed [SAMPLE_W-1:0] limit;
   logic [CMP_W-1:0]           var9, var4, dsq_ext;
   logic signed [SAMPLE_W+1:0] step, step_min;
   logic [STREAK_W-1:0]        streak_in;
   logic [LEVEL_W-1:0]         level_in;
   logic                       trend_upd, streak_rise;
   logic [VW:0]                rb_sum;
   logic                       rb_ge;
   logic [RW-1:0]              root;
   logic                       rem_ge;
   logic [SCORE_W-1:0]         q_in;
   logic                       fin_valid;
   logic [SCORE_W-1:0]         fin_score;
   logic                       escalate;
   logic                       mem_we;

   assign ci        = CW'(chan_ff);
   assign alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign alpha_inv = ALPHA_ONE - alpha_sat;
   assign addr      = AW'(ci * WINDOW_LEN) + AW'(pos_ff[ci]);
   assign full      = fill_ff[ci] >= NW'(WINDOW_LEN);
   assign n_in      = full ? fill_ff[ci] : NW'(fill_ff[ci] + 1'b1);
   assign mem_we    = (state_ff == ST_W2);

   assign num_sum = acc_ff + mul_p_ff;
   assign num_shr = num_sum >>> 8;
   assign sm_in   = (fill_ff[ci] == '0) ? signed'({sample_ff, FRAC_BITS'(0)})
                                        : SM_W'(num_shr);
   assign vq      = (sm_in >>> FRAC_BITS)
                    + SM_W'(sm_in[SM_W-1] && (sm_in[FRAC_BITS-1:0] != '0));
   assign v_in    = vq[SAMPLE_W-1:0];

   assign dmag_in = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);

   always_comb begin
      case (state_ff)
         ST_RD: begin
            mul_a = MA_W'(sample_ff);
            mul_b = MB_W'(alpha_sat);
         end
         ST_F2: begin
            mul_a = MA_W'(sm_ff[ci]);
            mul_b = MB_W'(alpha_inv);
         end
         ST_F3: begin
            mul_a = MA_W'(rd_ff);
            mul_b = MB_W'(rd_ff);
         end
         ST_W1: begin
            mul_a = MA_W'(v_ff);
            mul_b = MB_W'(v_ff);
         end
         ST_W2: begin
            mul_a = MA_W'(v_ff);
            mul_b = MB_W'(n_in);
         end
         ST_W3: begin
            mul_a = MA_W'(wsq_ff);
            mul_b = MB_W'(n_ff);
         end
         ST_W4: begin
            mul_a = MA_W'(wsum_ff);
            mul_b = MB_W'(wsum_ff);
         end
         ST_W5: begin
            mul_a = MA_W'(dmag_in);
            mul_b = MB_W'(dmag_in);
         end
         ST_W6: begin
            mul_a = MA_W'(dmag_ff);
            mul_b = MB_W'(SCORE_MAX);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (ci == CW'(0)) begin
         limit = lim_gas_ff;
      end else if (ci == CW'(1)) begin
         limit = lim_temp_ff;
      end else begin
         limit = lim_hum_ff;
      end
   end

   assign var9     = CMP_W'(var_ff) + (CMP_W'(var_ff) << 3);
   assign var4     = CMP_W'(var_ff) << 2;
   assign dsq_ext  = CMP_W'(dsq_ff);
   assign step     = (SAMPLE_W+2)'(v_ff) - (SAMPLE_W+2)'(prev_ff[ci]);
   assign step_min = signed'({2'b00, trend_step_ff});
   assign streak_rise = step > step_min;
   assign streak_in = streak_rise ? ((streak_ff[ci] == STREAK_MAX) ? STREAK_MAX
                                     : streak_ff[ci] + 1'b1)
                                  : '0;

   always_comb begin
      trend_upd = 1'b0;
      if (v_ff > limit) begin
         level_in = LVL_ANOM;
      end else if ((var_ff != '0) && (dsq_ext > var9)) begin
         level_in = LVL_ANOM;
      end else if ((var_ff != '0) && (dsq_ext > var4)) begin
         level_in = LVL_WARN;
      end else begin
         trend_upd = 1'b1;
         level_in  = (streak_rise && (streak_in >= trend_run_ff)) ? LVL_WARN : LVL_NORMAL;
      end
   end

   assign rb_sum = (VW+1)'(r_ff) + (VW+1)'(bit_ff);
   assign rb_ge  = (VW+1)'(x_ff) >= rb_sum;
   assign root   = r_ff[RW-1:0];
   assign rem_ge = rem_ff >= den_ff;
   assign q_in   = {q_ff[SCORE_W-2:0], rem_ge};

   always_comb begin
      fin_valid = 1'b0;
      fin_score = q_in;
      case (state_ff)
         ST_PREP: begin
            if (var_ff == '0) begin
               fin_valid = 1'b1;
               fin_score = (dmag_ff != '0) ? SCORE_MAX : '0;
            end else if (DW'(dmag_ff) >= DW'(root)) begin
               fin_valid = 1'b1;
               fin_score = SCORE_MAX;
            end
         end
         ST_DIV: begin
            fin_valid = (cnt_ff == CNT_W'(1));
         end
         default: begin
            fin_valid = 1'b0;
         end
      endcase
   end

   assign escalate = (level_ff == LVL_WARN) && (chan_ff == CHAN_W'(0))
                     && (latest_ff[CW'(1)] > $signed(16'd0))
                     && (latest_ff[CW'(2)] > $signed(16'd0))
                     && (latest_ff[CW'(1)] > signed'({1'b0, combo_temp_ff}))
                     && (latest_ff[CW'(2)] > signed'({1'b0, combo_hum_ff}));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[addr] <= v_ff;
      end
      rd_ff <= window_mem[addr];
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         alpha_ff      <= 9'd77;
         lim_gas_ff    <= 16'sd10000;
         lim_temp_ff   <= 16'sd800;
         lim_hum_ff    <= 16'sd900;
         combo_temp_ff <= 15'd700;
         combo_hum_ff  <= 15'd800;
         trend_step_ff <= 16'd1;
         trend_run_ff  <= 4'd3;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            pos_ff[i]    <= '0;
            fill_ff[i]   <= '0;
            sm_ff[i]     <= '0;
            sum_ff[i]    <= '0;
            sq_ff[i]     <= '0;
            latest_ff[i] <= '0;
            prev_ff[i]   <= '0;
            streak_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHA:      alpha_ff      <= csr_wdata[ALPHA_W-1:0];
               CSR_LIMIT_GAS:  lim_gas_ff    <= signed'(csr_wdata);
               CSR_LIMIT_TEMP: lim_temp_ff   <= signed'(csr_wdata);
               CSR_LIMIT_HUM:  lim_hum_ff    <= signed'(csr_wdata);
               CSR_COMBO_TEMP: combo_temp_ff <= csr_wdata[14:0];
               CSR_COMBO_HUM:  combo_hum_ff  <= csr_wdata[14:0];
               CSR_TREND_STEP: trend_step_ff <= csr_wdata;
               CSR_TREND_RUN:  trend_run_ff  <= csr_wdata[STREAK_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  chan_ff   <= req_tuser;
                  sample_ff <= signed'(req_tdata);
                  if (int'(req_tuser) < CHANNEL_COUNT) begin
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_RD: begin
               state_ff <= ST_F2;
            end
            ST_F2: begin
               acc_ff   <= mul_p_ff <<< FRAC_BITS;
               state_ff <= ST_F3;
            end
            ST_F3: begin
               sm_ff[ci] <= sm_in;
               v_ff      <= v_in;
               state_ff  <= ST_W1;
            end
            ST_W1: begin
               wsum_ff  <= full ? sum_ff[ci] - SUM_W'(rd_ff) : sum_ff[ci];
               wsq_ff   <= full ? sq_ff[ci] - SQ_W'(mul_p_ff) : sq_ff[ci];
               state_ff <= ST_W2;
            end
            ST_W2: begin
               wsum_ff       <= wsum_ff + SUM_W'(v_ff);
               wsq_ff        <= wsq_ff + SQ_W'(mul_p_ff);
               n_ff          <= n_in;
               fill_ff[ci]   <= n_in;
               pos_ff[ci]    <= (pos_ff[ci] == PW'(WINDOW_LEN - 1)) ? '0
                                : pos_ff[ci] + 1'b1;
               latest_ff[ci] <= v_ff;
               state_ff      <= ST_W3;
            end
            ST_W3: begin
               d_ff       <= DW'(mul_p_ff) - DW'(wsum_ff);
               sum_ff[ci] <= wsum_ff;
               sq_ff[ci]  <= wsq_ff;
               state_ff   <= ST_W4;
            end
            ST_W4: begin
               nsq_ff   <= VW'(mul_p_ff);
               state_ff <= ST_W5;
            end
            ST_W5: begin
               var_ff   <= nsq_ff - VW'(mul_p_ff);
               dmag_ff  <= dmag_in;
               state_ff <= ST_W6;
            end
            ST_W6: begin
               dsq_ff   <= (2*DW)'(mul_p_ff);
               x_ff     <= var_ff;
               r_ff     <= '0;
               bit_ff   <= VW'(1) << (2 * (RW - 1));
               cnt_ff   <= CNT_W'(RW);
               state_ff <= ST_LVL;
            end
            ST_LVL: begin
               num_ff   <= QW'(mul_p_ff);
               level_ff <= level_in;
               if (trend_upd) begin
                  prev_ff[ci]   <= v_ff;
                  streak_ff[ci] <= streak_in;
               end
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (rb_ge) begin
                  x_ff <= x_ff - VW'(rb_sum);
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               rem_ff <= num_ff;
               den_ff <= QW'(root) << (DIV_STEPS - 1);
               q_ff   <= '0;
               cnt_ff <= CNT_W'(DIV_STEPS);
               state_ff <= fin_valid ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
               if (rem_ge) begin
                  rem_ff <= rem_ff - den_ff;
               end
               den_ff <= den_ff >> 1;
               q_ff   <= q_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (fin_valid) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (fin_valid) begin
            rsp_valid_ff <= 1'b1;
            rsp_chan_ff  <= chan_ff;
            rsp_v_ff     <= v_ff;
            rsp_level_ff <= escalate ? LVL_ANOM : level_ff;
            rsp_score_ff <= escalate ? SCORE_MAX : fin_score;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tdata  = {4'b0000, rsp_score_ff, rsp_level_ff, rsp_v_ff};

   `WSAS_ASSERT_NOW(a_busy_while_out, rsp_tvalid, !req_tready, "request taken while a result is pending")
   `WSAS_ASSERT_NOW(a_score_range, rsp_tvalid, rsp_tdata[27:18] <= SCORE_MAX, "score above saturation")
   `WSAS_ASSERT_NEXT(a_take_busy, req_tvalid && req_tready && (int'(req_tuser) < CHANNEL_COUNT), !req_tready && !rsp_tvalid, "block not busy after accepting a transaction")

endmodule

[bench/window_sigma_anomaly_scorer_test.sv]
// Self-checking bench for window_sigma_anomaly_scorer: directed table, an escalation run, then random samples.
// Predicts each response with a per-channel filter/window/score model; depends on wsas_pkg.
`timescale 1ns / 1ps

module window_sigma_anomaly_scorer_test
   import wsas_pkg::*;
;

   localparam int WLEN = 16;
   localparam int NCH = 3;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [1:0]  chan;
      logic [15:0] value;
      logic [1:0]  level;
      logic [9:0]  score;
   } score_t;

   typedef struct {
      logic [1:0]  chan;
      logic [15:0] sample;
      bit          typed;
      logic [1:0]  level;
      logic [9:0]  score;
   } stim_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = 0;
   logic [1:0] req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   window_sigma_anomaly_scorer u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // register copy
   longint alpha_q8, lim [NCH], combo_t, combo_h, min_step, run_len;
   // channel state
   longint ring [NCH][WLEN];
   int wpos [NCH], fill [NCH], streak [NCH];
   longint filt_q8 [NCH], wsum [NCH], wsq [NCH], latest [NCH], prev_v [NCH];

   score_t pending_scores [$];
   int errors = 0;
   int cycles = 0;
   int stall_left = 0;
   bit drain_quiet = 0;

   function automatic longint isqrt(longint x);
      longint r;
      r = 0;
      for (longint b = 64'd1 << 62; b != 0; b >>= 2) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
      end
      return r;
   endfunction

   function automatic score_t predict_score(int c, logic [15:0] raw);
      longint s, a, num, v, d, var_, dm, q, root, step, limit;
      int p;
      score_t r;
      s = longint'($signed(raw));
      a = alpha_q8 > 256 ? 256 : alpha_q8;
      if (fill[c] == 0) begin
         filt_q8[c] = s * 256;
      end else begin
         num = a * s * 256 + (256 - a) * filt_q8[c];
         filt_q8[c] = num >= 0 ? num / 256 : -((-num + 255) / 256);
      end
      v = filt_q8[c] / 256;
      p = wpos[c];
      if (fill[c] >= WLEN) begin
         wsum[c] -= ring[c][p];
         wsq[c] -= ring[c][p] * ring[c][p];
      end else begin
         fill[c]++;
      end
      ring[c][p] = v;
      wsum[c] += v;
      wsq[c] += v * v;
      wpos[c] = (p + 1) % WLEN;
      latest[c] = v;
      d = fill[c] * v - wsum[c];
      var_ = fill[c] * wsq[c] - wsum[c] * wsum[c];
      dm = d < 0 ? -d : d;
      limit = lim[c];
      if (v > limit) r.level = LVL_ANOM;
      else if (var_ > 0 && dm * dm > 9 * var_) r.level = LVL_ANOM;
      else if (var_ > 0 && dm * dm > 4 * var_) r.level = LVL_WARN;
      else r.level = LVL_NORMAL;
      if (r.level == LVL_NORMAL) begin
         step = v - prev_v[c];
         prev_v[c] = v;
         if (step > min_step) begin
            if (streak[c] < 15) streak[c]++;
            if (streak[c] >= run_len) r.level = LVL_WARN;
         end else begin
            streak[c] = 0;
         end
      end
      if (var_ > 0) begin
         root = isqrt(var_);
         q = root != 0 ? (1000 * dm) / root : 1000;
         r.score = q > 1000 ? SCORE_MAX : q[9:0];
      end else begin
         r.score = dm != 0 ? SCORE_MAX : 10'd0;
      end
      if (r.level == LVL_WARN && c == 0 && latest[1] > 0 && latest[2] > 0
          && latest[1] > combo_t && latest[2] > combo_h) begin
         r.level = LVL_ANOM;
         r.score = SCORE_MAX;
      end
      r.chan = c[1:0];
      r.value = v[15:0];
      return r;
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [15:0] val);
      case (idx)
         CSR_ALPHA: alpha_q8 = val[8:0];
         CSR_LIMIT_GAS: lim[0] = longint'($signed(val));
         CSR_LIMIT_TEMP: lim[1] = longint'($signed(val));
         CSR_LIMIT_HUM: lim[2] = longint'($signed(val));
         CSR_COMBO_TEMP: combo_t = val[14:0];
         CSR_COMBO_HUM: combo_h = val[14:0];
         CSR_TREND_STEP: min_step = val;
         CSR_TREND_RUN: run_len = val[3:0];
         default: ;
      endcase
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      apply_csr(idx, val);
      @(posedge clock);
   endtask

   task automatic send_sample(logic [1:0] c, logic [15:0] s, bit typed = 0,
                              logic [1:0] lvl = 0, logic [9:0] sc = 0);
      score_t e;
      if (!drain_quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= c;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      if (c < NCH) begin
         e = predict_score(c, s);
         if (typed && (e.level != lvl || e.score != sc)) begin
            $error("table row ch %0d level exp %0d got %0d score exp %0d got %0d",
                   c, lvl, e.level, sc, e.score);
            errors++;
         end
         pending_scores.push_back(e);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || drain_quiet) begin
         rsp_tready <= 1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_tready && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         stall_left <= $urandom_range(0, 3);
      end else if (!rsp_tready) begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      score_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $error("unexpected response ch %0d", rsp_tuser);
            errors++;
         end else begin
            e = pending_scores.pop_front();
            if (rsp_tuser !== e.chan) begin
               $error("out_channel exp %0d got %0d", e.chan, rsp_tuser); errors++;
            end
            if (rsp_tdata[15:0] !== e.value) begin
               $error("smoothed_sample exp %0d got %0d", $signed(e.value),
                      $signed(rsp_tdata[15:0])); errors++;
            end
            if (rsp_tdata[17:16] !== e.level) begin
               $error("level exp %0d got %0d", e.level, rsp_tdata[17:16]); errors++;
            end
            if (rsp_tdata[27:18] !== e.score) begin
               $error("score exp %0d got %0d", e.score, rsp_tdata[27:18]); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL window_sigma_anomaly_scorer");
         $finish;
      end
   end

   stim_row_t directed [] = '{
      '{2'd0, 16'sd100, 1, LVL_NORMAL, 10'd0},
      '{2'd1, 16'h8000, 1, LVL_NORMAL, 10'd0},
      '{2'd2, 16'h7fff, 1, LVL_ANOM, 10'd0},
      '{2'd3, 16'h1234, 0, 0, 0},
      '{2'd0, 16'h7fff, 0, 0, 0},
      '{2'd0, 16'h8000, 0, 0, 0},
      '{2'd1, 16'h7fff, 0, 0, 0},
      '{2'd1, 16'h7fff, 0, 0, 0},
      '{2'd2, 16'h8000, 0, 0, 0},
      '{2'd0, 16'sd200, 0, 0, 0},
      '{2'd0, 16'sd400, 0, 0, 0},
      '{2'd0, 16'sd800, 0, 0, 0},
      '{2'd0, 16'sd1600, 0, 0, 0},
      '{2'd3, 16'hffff, 0, 0, 0}
   };

   int ramp;

   initial begin
      apply_csr(CSR_ALPHA, 16'd77);
      apply_csr(CSR_LIMIT_GAS, 16'd10000);
      apply_csr(CSR_LIMIT_TEMP, 16'd800);
      apply_csr(CSR_LIMIT_HUM, 16'd900);
      apply_csr(CSR_COMBO_TEMP, 16'd700);
      apply_csr(CSR_COMBO_HUM, 16'd800);
      apply_csr(CSR_TREND_STEP, 16'd1);
      apply_csr(CSR_TREND_RUN, 16'd3);
      for (int c = 0; c < NCH; c++) begin
         wpos[c] = 0; fill[c] = 0; streak[c] = 0; filt_q8[c] = 0;
         wsum[c] = 0; wsq[c] = 0; latest[c] = 0; prev_v[c] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i])
         send_sample(directed[i].chan, directed[i].sample, directed[i].typed,
                     directed[i].level, directed[i].score);
      wait_idle();

      // escalation setup: hot temperature and humidity, then a gas ramp
      write_csr(CSR_ALPHA, 16'd256);
      write_csr(CSR_LIMIT_TEMP, 16'h7fff);
      write_csr(CSR_LIMIT_HUM, 16'h7fff);
      write_csr(CSR_COMBO_TEMP, 16'd100);
      write_csr(CSR_COMBO_HUM, 16'd100);
      write_csr(CSR_TREND_RUN, 16'd0);
      send_sample(2'd1, 16'sd500);
      send_sample(2'd2, 16'sd500);
      for (int i = 0; i < 6; i++) send_sample(2'd0, 16'(i * 300));
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: write_csr(CSR_ALPHA, 16'(ph == 0 ? 0 : 511));
            1: write_csr(CSR_ALPHA, 16'($urandom_range(1, 256)));
            default: write_csr(CSR_ALPHA, 16'($urandom_range(0, 511)));
         endcase
         write_csr(CSR_LIMIT_GAS, ph == 3 ? 16'h8000 : 16'($urandom_range(0, 65535)));
         write_csr(CSR_LIMIT_TEMP, ph == 5 ? 16'h7fff : 16'($urandom_range(0, 65535)));
         write_csr(CSR_LIMIT_HUM, 16'($urandom_range(0, 65535)));
         write_csr(CSR_COMBO_TEMP, ph == 2 ? 16'h7fff : 16'($urandom_range(0, 2000)));
         write_csr(CSR_COMBO_HUM, ph == 2 ? 16'd0 : 16'($urandom_range(0, 2000)));
         write_csr(CSR_TREND_STEP, ph == 4 ? 16'hffff : 16'($urandom_range(0, 50)));
         write_csr(CSR_TREND_RUN, ph == 6 ? 16'd15 : 16'($urandom_range(0, 15)));
         ramp = int'($urandom_range(0, 4000)) - 2000;
         for (int i = 0; i < 100; i++) begin
            drain_quiet = (ph == 7 && i >= 60);
            case ($urandom_range(0, 9))
               0: send_sample(2'd3, 16'($urandom));
               1, 2: send_sample(2'($urandom_range(0, 2)), 16'($urandom));
               3, 4, 5: begin
                  ramp += $urandom_range(0, 80);
                  send_sample(2'd0, 16'(ramp));
               end
               default: send_sample(2'($urandom_range(0, 2)),
                                    16'($urandom_range(0, 1200)));
            endcase
         end
         wait_idle();
      end

      if (errors == 0)
         $display("PASS window_sigma_anomaly_scorer");
      else
         $display("FAIL window_sigma_anomaly_scorer");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/wsas_pkg.sv
rtl/window_sigma_anomaly_scorer.sv
bench/window_sigma_anomaly_scorer_test.sv
